### hw/rtl/assert_macros.svh
// ---------------------------------------------------------------------------
// assert_macros.svh
// concurrent assertion helpers, empty when SYNTHESIS is defined
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: label");

`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: label");

`else

`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons)

`define ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

### hw/rtl/mclc_pkg.sv
// ---------------------------------------------------------------------------
// mclc_pkg
// types and codes for the mosi coherence line controller
// ---------------------------------------------------------------------------
package mclc_pkg;

    typedef enum logic [2:0] {
        ST_I  = 3'd0,
        ST_S  = 3'd1,
        ST_O  = 3'd2,
        ST_M  = 3'd3,
        ST_IS = 3'd4,
        ST_IM = 3'd5,
        ST_SM = 3'd6,
        ST_OM = 3'd7
    } t_state;

    typedef enum logic [2:0] {
        ACT_LOAD  = 3'd0,
        ACT_STORE = 3'd1,
        ACT_GETS  = 3'd2,
        ACT_GETM  = 3'd3,
        ACT_DATA  = 3'd4
    } t_action;

    typedef enum logic [1:0] {
        BUS_NONE = 2'd0,
        BUS_GETS = 2'd1,
        BUS_GETM = 2'd2
    } t_bus;

    typedef enum logic [1:0] {
        ERR_OK      = 2'd0,
        ERR_PENDING = 2'd1,
        ERR_DATA    = 2'd2
    } t_err;

    localparam int unsigned ACTION_W = 3;
    localparam int unsigned STATE_W  = 3;

endpackage

### hw/rtl/mosi_coherence_line_controller_unit.sv
// ---------------------------------------------------------------------------
// mosi_coherence_line_controller_unit
// one cache line controller, snooping mosi protocol with transient states
// ---------------------------------------------------------------------------
// the result is registered in the output register, or in the skid on a stall
// throughput: one item per cycle while the skid is empty, limited by the single
// line state register; a two-entry output (result register plus skid) keeps
// input ready after the output stalls, until an item fills the skid
// reset: synchronous active low, line state to I, output and skid empty
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module mosi_coherence_line_controller_unit #(
    parameter int unsigned ADDRESS_BITS   = 32,
    parameter int unsigned MODULE_ID_BITS = 4
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_s_tvalid,
    output logic                  o_s_tready,
    // address, requester_id
    input  logic [((ADDRESS_BITS + MODULE_ID_BITS + 7) / 8) * 8 - 1:0] i_s_tdata,
    // action
    input  logic [2:0]            i_s_tuser,
    output logic                  o_m_tvalid,
    input  logic                  i_m_tready,
    // bus_request, data_to_processor, data_on_bus, destination_id,
    // address_out, miss, error_code, line_state
    output logic [((MODULE_ID_BITS + ADDRESS_BITS + 17) / 8) * 8 - 1:0] o_m_tdata
);

    localparam int unsigned IN_W       = ADDRESS_BITS + MODULE_ID_BITS;
    localparam int unsigned OUT_W      = 2 + 1 + 1 + MODULE_ID_BITS + ADDRESS_BITS + 1 + 2 + 3;
    localparam int unsigned OUT_DATA_W = ((OUT_W + 7) / 8) * 8;

    logic [ADDRESS_BITS-1:0]   w_addr;
    logic [MODULE_ID_BITS-1:0] w_rid;
    logic [2:0]                w_action;

    mclc_pkg::t_state r_state;
    mclc_pkg::t_state n_state;
    mclc_pkg::t_bus   w_bus;
    mclc_pkg::t_err   w_err;
    logic             w_to_proc;
    logic             w_on_bus;
    logic             w_miss;
    logic [OUT_W-1:0] w_result;

    logic             r_out_valid;
    logic [OUT_W-1:0] r_out_data;
    logic             r_skid_valid;
    logic [OUT_W-1:0] r_skid_data;
    logic             w_accept;

    assign w_addr   = i_s_tdata[ADDRESS_BITS-1:0];
    assign w_rid    = i_s_tdata[IN_W-1:ADDRESS_BITS];
    assign w_action = i_s_tuser;

    assign o_s_tready = !r_skid_valid;
    assign w_accept   = i_s_tvalid && o_s_tready;

    always_comb begin
        n_state   = r_state;
        w_bus     = mclc_pkg::BUS_NONE;
        w_err     = mclc_pkg::ERR_OK;
        w_to_proc = 1'b0;
        w_on_bus  = 1'b0;
        w_miss    = 1'b0;
        if (w_action == mclc_pkg::ACT_LOAD || w_action == mclc_pkg::ACT_STORE) begin
            case (r_state)
                mclc_pkg::ST_I: begin
                    w_miss = 1'b1;
                    if (w_action == mclc_pkg::ACT_STORE) begin
                        w_bus   = mclc_pkg::BUS_GETM;
                        n_state = mclc_pkg::ST_IM;
                    end else begin
                        w_bus   = mclc_pkg::BUS_GETS;
                        n_state = mclc_pkg::ST_IS;
                    end
                end
                mclc_pkg::ST_S, mclc_pkg::ST_O: begin
                    if (w_action == mclc_pkg::ACT_STORE) begin
                        w_bus   = mclc_pkg::BUS_GETM;
                        w_miss  = 1'b1;
                        n_state = (r_state == mclc_pkg::ST_S) ? mclc_pkg::ST_SM
                                                              : mclc_pkg::ST_OM;
                    end else begin
                        w_to_proc = 1'b1;
                    end
                end
                mclc_pkg::ST_M: begin
                    w_to_proc = 1'b1;
                end
                default: begin
                    w_err = mclc_pkg::ERR_PENDING;
                end
            endcase
        end else if (w_action == mclc_pkg::ACT_GETS || w_action == mclc_pkg::ACT_GETM) begin
            case (r_state)
                mclc_pkg::ST_S: begin
                    if (w_action == mclc_pkg::ACT_GETM) n_state = mclc_pkg::ST_I;
                end
                mclc_pkg::ST_O: begin
                    w_on_bus = 1'b1;
                    if (w_action == mclc_pkg::ACT_GETM) n_state = mclc_pkg::ST_I;
                end
                mclc_pkg::ST_M: begin
                    w_on_bus = 1'b1;
                    n_state  = (w_action == mclc_pkg::ACT_GETM) ? mclc_pkg::ST_I
                                                                : mclc_pkg::ST_O;
                end
                mclc_pkg::ST_OM: begin
                    w_on_bus = 1'b1;
                    if (w_action == mclc_pkg::ACT_GETM) n_state = mclc_pkg::ST_IM;
                end
                default: begin
                end
            endcase
        end else if (w_action == mclc_pkg::ACT_DATA) begin
            case (r_state)
                mclc_pkg::ST_S, mclc_pkg::ST_O, mclc_pkg::ST_M: begin
                    w_err = mclc_pkg::ERR_DATA;
                end
                mclc_pkg::ST_IS: begin
                    w_to_proc = 1'b1;
                    n_state   = mclc_pkg::ST_S;
                end
                mclc_pkg::ST_IM, mclc_pkg::ST_SM, mclc_pkg::ST_OM: begin
                    w_to_proc = 1'b1;
                    n_state   = mclc_pkg::ST_M;
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        w_result = {
            n_state,
            w_err,
            w_miss,
            (w_bus != mclc_pkg::BUS_NONE || w_to_proc || w_on_bus) ? w_addr
                                                                    : {ADDRESS_BITS{1'b0}},
            w_on_bus ? w_rid : {MODULE_ID_BITS{1'b0}},
            w_on_bus,
            w_to_proc,
            w_bus
        };
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= mclc_pkg::ST_I;
        end else if (w_accept) begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (!r_out_valid || i_m_tready) begin
            if (r_skid_valid) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid  <= w_accept;
            end
        end else if (w_accept) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_out_valid || i_m_tready) begin
            r_out_data <= r_skid_valid ? r_skid_data : w_result;
        end else if (w_accept) begin
            r_skid_data <= w_result;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = OUT_DATA_W'(r_out_data);

    // skid only fills behind a stalled result
    `ASSERT_IMPLIES(a_skid_behind_out, i_clk, i_rst_n, r_skid_valid, r_out_valid)
    // an error leaves the line state alone
    `ASSERT_NEXT(a_err_keeps_state, i_clk, i_rst_n,
        w_accept && w_err != mclc_pkg::ERR_OK, r_state == $past(r_state))
    // an error result carries no bus or processor action
    `ASSERT_IMPLIES(a_err_no_action, i_clk, i_rst_n,
        w_err != mclc_pkg::ERR_OK,
        w_bus == mclc_pkg::BUS_NONE && !w_to_proc && !w_on_bus && !w_miss)
    // a stalled result holds until taken
    `ASSERT_NEXT(a_out_holds, i_clk, i_rst_n,
        r_out_valid && !i_m_tready, r_out_valid && $stable(r_out_data))

endmodule

### bench/mosi_coherence_line_controller_unit_tb.sv
// ---------------------------------------------------------------------------
// mosi_coherence_line_controller_unit_tb
// self-checking bench for the mosi line controller: a directed walk through
// every state and action, then random request and snoop mixes under
// several idle and stall patterns, each result checked against a line
// state tracker kept in the bench
// ---------------------------------------------------------------------------
module mosi_coherence_line_controller_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned ADDR_W     = 32;
    localparam int unsigned MID_W      = 4;
    localparam int unsigned IN_W       = 40;
    localparam int unsigned OUT_W      = 48;
    localparam int unsigned RES_W      = 46;
    localparam int unsigned RAND_ITEMS = 260;
    localparam int unsigned HOLD_LEN   = 200;
    localparam int unsigned IDLE_LIMIT = 4000;

    // fields from the top bit down, so bus_request sits lowest
    typedef struct packed {
        logic [2:0]        line_state;
        logic [1:0]        error_code;
        logic              miss;
        logic [ADDR_W-1:0] address_out;
        logic [MID_W-1:0]  destination_id;
        logic              data_on_bus;
        logic              data_to_processor;
        logic [1:0]        bus_request;
    } t_line_result;

    class line_scoreboard;
        mclc_pkg::t_state line_st;
        t_line_result     pending_results[$];
        int               failures;

        function new();
            line_st  = mclc_pkg::ST_I;
            failures = 0;
        endfunction

        function void note_item(logic [2:0] act, logic [ADDR_W-1:0] addr,
                                logic [MID_W-1:0] rid);
            t_line_result     r;
            mclc_pkg::t_state nxt;
            r   = '0;
            nxt = line_st;
            case (act)
                mclc_pkg::ACT_LOAD, mclc_pkg::ACT_STORE: begin
                    case (line_st)
                        mclc_pkg::ST_I: begin
                            r.miss = 1'b1;
                            if (act == mclc_pkg::ACT_STORE) begin
                                r.bus_request = mclc_pkg::BUS_GETM;
                                nxt = mclc_pkg::ST_IM;
                            end else begin
                                r.bus_request = mclc_pkg::BUS_GETS;
                                nxt = mclc_pkg::ST_IS;
                            end
                        end
                        mclc_pkg::ST_S, mclc_pkg::ST_O: begin
                            if (act == mclc_pkg::ACT_STORE) begin
                                r.bus_request = mclc_pkg::BUS_GETM;
                                r.miss = 1'b1;
                                if (line_st == mclc_pkg::ST_S) nxt = mclc_pkg::ST_SM;
                                else nxt = mclc_pkg::ST_OM;
                            end else begin
                                r.data_to_processor = 1'b1;
                            end
                        end
                        mclc_pkg::ST_M: r.data_to_processor = 1'b1;
                        default: r.error_code = mclc_pkg::ERR_PENDING;
                    endcase
                end
                mclc_pkg::ACT_GETS, mclc_pkg::ACT_GETM: begin
                    case (line_st)
                        mclc_pkg::ST_S: if (act == mclc_pkg::ACT_GETM) nxt = mclc_pkg::ST_I;
                        mclc_pkg::ST_O: begin
                            r.data_on_bus = 1'b1;
                            if (act == mclc_pkg::ACT_GETM) nxt = mclc_pkg::ST_I;
                        end
                        mclc_pkg::ST_M: begin
                            r.data_on_bus = 1'b1;
                            if (act == mclc_pkg::ACT_GETM) nxt = mclc_pkg::ST_I;
                            else nxt = mclc_pkg::ST_O;
                        end
                        mclc_pkg::ST_OM: begin
                            r.data_on_bus = 1'b1;
                            if (act == mclc_pkg::ACT_GETM) nxt = mclc_pkg::ST_IM;
                        end
                        default: ;
                    endcase
                end
                mclc_pkg::ACT_DATA: begin
                    case (line_st)
                        mclc_pkg::ST_S, mclc_pkg::ST_O, mclc_pkg::ST_M:
                            r.error_code = mclc_pkg::ERR_DATA;
                        mclc_pkg::ST_IS: begin
                            r.data_to_processor = 1'b1;
                            nxt = mclc_pkg::ST_S;
                        end
                        mclc_pkg::ST_IM, mclc_pkg::ST_SM, mclc_pkg::ST_OM: begin
                            r.data_to_processor = 1'b1;
                            nxt = mclc_pkg::ST_M;
                        end
                        default: ;
                    endcase
                end
                default: ;
            endcase
            line_st = nxt;
            if (r.data_on_bus) r.destination_id = rid;
            if (r.bus_request != mclc_pkg::BUS_NONE || r.data_to_processor || r.data_on_bus)
                r.address_out = addr;
            r.line_state = line_st;
            pending_results.push_back(r);
        endfunction

        function void compare_field(string name, logic [ADDR_W-1:0] want,
                                    logic [ADDR_W-1:0] got);
            if (want !== got) begin
                $error("%s mismatch: expected %0h, got %0h", name, want, got);
                failures++;
            end
        endfunction

        function void check_result(logic [OUT_W-1:0] data);
            t_line_result want;
            t_line_result got;
            if (pending_results.size() == 0) begin
                $error("result item with nothing expected: %0h", data);
                failures++;
                return;
            end
            want = pending_results.pop_front();
            got  = data[RES_W-1:0];
            compare_field("bus_request", ADDR_W'(want.bus_request),
                          ADDR_W'(got.bus_request));
            compare_field("data_to_processor", ADDR_W'(want.data_to_processor),
                          ADDR_W'(got.data_to_processor));
            compare_field("data_on_bus", ADDR_W'(want.data_on_bus),
                          ADDR_W'(got.data_on_bus));
            compare_field("destination_id", ADDR_W'(want.destination_id),
                          ADDR_W'(got.destination_id));
            compare_field("address_out", want.address_out, got.address_out);
            compare_field("miss", ADDR_W'(want.miss), ADDR_W'(got.miss));
            compare_field("error_code", ADDR_W'(want.error_code),
                          ADDR_W'(got.error_code));
            compare_field("line_state", ADDR_W'(want.line_state),
                          ADDR_W'(got.line_state));
        endfunction
    endclass

    logic             clk = 1'b0;
    logic             rst_n = 1'b0;
    logic             s_valid = 1'b0;
    logic             s_ready;
    logic [IN_W-1:0]  s_data = '0;
    logic [2:0]       s_user = '0;
    logic             m_valid;
    logic             m_ready = 1'b0;
    logic [OUT_W-1:0] m_data;

    int unsigned send_idle_pct = 0;
    int unsigned stall_pct = 0;
    int unsigned hold_requests = 0;
    int unsigned holds_done = 0;
    int unsigned idle_cycles = 0;

    line_scoreboard sb = new();

    mosi_coherence_line_controller_unit #(
        .ADDRESS_BITS  (ADDR_W),
        .MODULE_ID_BITS(MID_W)
    ) u_dut (
        .i_clk     (clk),
        .i_rst_n   (rst_n),
        .i_s_tvalid(s_valid),
        .o_s_tready(s_ready),
        // address, requester_id
        .i_s_tdata (s_data),
        // action
        .i_s_tuser (s_user),
        .o_m_tvalid(m_valid),
        .i_m_tready(m_ready),
        // bus_request, data_to_processor, data_on_bus, destination_id,
        // address_out, miss, error_code, line_state
        .o_m_tdata (m_data)
    );

    always begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // accepted items on both sides
    always @(posedge clk) begin
        if (rst_n) begin
            if (s_valid && s_ready)
                sb.note_item(s_user, s_data[ADDR_W-1:0], s_data[ADDR_W+MID_W-1:ADDR_W]);
            if (m_valid && m_ready)
                sb.check_result(m_data);
        end
    end

    // receiver: random stalls plus an occasional long hold-off
    initial begin
        forever begin
            @(posedge clk);
            if (hold_requests != holds_done) begin
                m_ready <= 1'b0;
                repeat (HOLD_LEN) @(posedge clk);
                holds_done++;
            end
            m_ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    always @(posedge clk) begin
        if (!rst_n || (s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("Verification failed");
                $finish;
            end
        end
    end

    task automatic send_item(logic [2:0] act, logic [ADDR_W-1:0] addr,
                             logic [MID_W-1:0] rid);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge clk);
        end
        s_valid <= 1'b1;
        s_user  <= act;
        s_data  <= {{(IN_W-ADDR_W-MID_W){1'b0}}, rid, addr};
        @(posedge clk);
        while (!s_ready) @(posedge clk);
    endtask

    task automatic drain_results();
        s_valid <= 1'b0;
        @(posedge clk);
        while (sb.pending_results.size() != 0) @(posedge clk);
    endtask

    task automatic send_random();
        int unsigned      pick;
        logic [2:0]       act;
        logic [ADDR_W-1:0] addr;
        pick = $urandom_range(99);
        if (pick < 25) act = mclc_pkg::ACT_LOAD;
        else if (pick < 45) act = mclc_pkg::ACT_STORE;
        else if (pick < 62) act = mclc_pkg::ACT_GETS;
        else if (pick < 77) act = mclc_pkg::ACT_GETM;
        else if (pick < 97) act = mclc_pkg::ACT_DATA;
        else act = 3'($urandom_range(mclc_pkg::ACT_DATA + 1,
                                     (1 << mclc_pkg::ACTION_W) - 1));
        case ($urandom_range(9))
            0: addr = '0;
            1: addr = '1;
            default: addr = $urandom;
        endcase
        send_item(act, addr, MID_W'($urandom_range((1 << MID_W) - 1)));
    endtask

    initial begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed walk through all states, errors and ignored items
        send_item(mclc_pkg::ACT_GETS, '1, '1);
        send_item(mclc_pkg::ACT_GETM, '0, '0);
        send_item(mclc_pkg::ACT_DATA, 32'h1234_5678, 4'h3);
        send_item(3'(mclc_pkg::ACT_DATA + 1), '1, '1);
        send_item(mclc_pkg::ACT_LOAD, 32'h0000_0040, 4'h1);
        send_item(mclc_pkg::ACT_STORE, '1, 4'h2);
        send_item(mclc_pkg::ACT_GETM, '1, '1);
        send_item(mclc_pkg::ACT_DATA, 32'hdead_beef, 4'h5);
        send_item(mclc_pkg::ACT_LOAD, '1, '0);
        send_item(mclc_pkg::ACT_DATA, '1, '1);
        send_item(mclc_pkg::ACT_GETS, 32'h8000_0000, '1);
        send_item(mclc_pkg::ACT_STORE, 32'h0000_0001, 4'h7);
        send_item(mclc_pkg::ACT_LOAD, '0, '0);
        send_item(mclc_pkg::ACT_DATA, 32'hcafe_f00d, 4'h8);
        send_item(mclc_pkg::ACT_STORE, '1, '1);
        send_item(mclc_pkg::ACT_DATA, '0, '0);
        send_item(mclc_pkg::ACT_GETS, '1, '1);
        send_item(mclc_pkg::ACT_LOAD, 32'h5555_aaaa, 4'ha);
        send_item(mclc_pkg::ACT_GETS, '0, '0);
        send_item(mclc_pkg::ACT_STORE, 32'haaaa_5555, 4'h5);
        send_item(mclc_pkg::ACT_GETS, '1, '1);
        send_item(mclc_pkg::ACT_GETM, 32'h0f0f_0f0f, 4'hc);
        send_item(mclc_pkg::ACT_DATA, '1, '0);
        send_item(mclc_pkg::ACT_GETM, '0, '1);
        send_item(3'((1 << mclc_pkg::ACTION_W) - 1), '1, '1);
        drain_results();

        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin send_idle_pct = 0;  stall_pct = 0;  end
                1: begin send_idle_pct = 58; stall_pct = 0;  end
                2: begin send_idle_pct = 0;  stall_pct = 58; end
                default: begin send_idle_pct = 37; stall_pct = 37; end
            endcase
            // long hold-off while items keep coming, so input backs up
            if (ph == 0 || ph == 3) hold_requests++;
            for (int n = 0; n < RAND_ITEMS; n++) send_random();
            drain_results();
        end

        repeat (4) @(posedge clk);
        if (sb.failures == 0 && sb.pending_results.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

### files.f
+incdir+hw/rtl
hw/rtl/mclc_pkg.sv
hw/rtl/mosi_coherence_line_controller_unit.sv
bench/mosi_coherence_line_controller_unit_tb.sv
